[rtl/yeah_cwc_pkg.sv]
`default_nettype none
package yeah_cwc_pkg;

    localparam int unsigned RTT_W     = 24;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CNT_W     = 16;
    localparam int unsigned FAST_W    = 17;

    // serial divider and multiplier operand widths
    localparam int unsigned DIVIDEND_W = 56;
    localparam int unsigned DIVISOR_W  = 24;
    localparam int unsigned MUL_A_W    = 32;
    localparam int unsigned MUL_B_W    = 24;
    localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
    localparam int unsigned DIV_CNT_W  = $clog2(DIVIDEND_W + 1);
    localparam int unsigned MUL_CNT_W  = $clog2(MUL_B_W + 1);

    localparam logic [WORD_W-1:0] RENO_FLOOR  = WORD_W'(2);
    localparam logic [CNT_W-1:0]  MIN_SAMPLES = CNT_W'(2);

    typedef enum logic [1:0] {
        CMD_RTT   = 2'd0,
        CMD_ACK   = 2'd1,
        CMD_STATE = 2'd2,
        CMD_LOSS  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        GROWTH_SLOW_START = 2'd0,
        GROWTH_SCALABLE   = 2'd1,
        GROWTH_RENO       = 2'd2
    } t_growth;

    localparam logic [CFG_IDX_W-1:0] CFG_BACKLOG_LIMIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_DIVISOR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOSS_SHIFT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECONGEST_SHIFT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_RATIO     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPETE_ROUNDS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_RESET      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_BYTES   = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIV_SEG,
        S_MUL_Q,
        S_DIV_Q,
        S_DIV_CUT,
        S_MUL_W,
        S_ROUND,
        S_MUL_LOSS,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

[rtl/yeah_cwc_in_if.sv]
`default_nettype none
interface yeah_cwc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [23:0] rtt_us;
    logic [31:0] cwnd_bytes;
    logic [31:0] ssthresh_bytes;
    logic [31:0] acked_seq;
    logic [31:0] next_seq;
    logic [31:0] in_flight_bytes;
    logic        state_open;

    modport source (output valid, cmd, rtt_us, cwnd_bytes, ssthresh_bytes, acked_seq,
                    next_seq, in_flight_bytes, state_open, input ready);
    modport sink (input valid, cmd, rtt_us, cwnd_bytes, ssthresh_bytes, acked_seq,
                  next_seq, in_flight_bytes, state_open, output ready);
endinterface
`default_nettype wire

[rtl/yeah_cwc_out_if.sv]
`default_nettype none
interface yeah_cwc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  growth_mode;
    logic        round_done;
    logic        window_changed;
    logic [31:0] cwnd_out;
    logic [31:0] ssthresh_out;
    logic [31:0] queue_estimate;

    modport source (output valid, growth_mode, round_done, window_changed, cwnd_out,
                    ssthresh_out, queue_estimate, input ready);
    modport sink (input valid, growth_mode, round_done, window_changed, cwnd_out,
                  ssthresh_out, queue_estimate, output ready);
endinterface
`default_nettype wire

[rtl/yeah_cwc_div.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module yeah_cwc_div (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_start,
    input  wire [yeah_cwc_pkg::DIVIDEND_W-1:0]  i_dividend,
    input  wire [yeah_cwc_pkg::DIVISOR_W-1:0]   i_divisor,
    output logic [yeah_cwc_pkg::DIVIDEND_W-1:0] o_quot,
    output logic                                o_done
);
    localparam int unsigned DW = yeah_cwc_pkg::DIVIDEND_W;
    localparam int unsigned VW = yeah_cwc_pkg::DIVISOR_W;
    localparam int unsigned CW = yeah_cwc_pkg::DIV_CNT_W;

    logic [DW-1:0] r_quot;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [VW:0]   trial;
    logic          fits;

    assign trial = {r_rem, r_quot[DW-1]};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DW-2:0], fits};
            r_rem  <= fits ? VW'(trial - {1'b0, r_div}) : trial[VW-1:0];
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;
endmodule
`default_nettype wire

[rtl/yeah_cwc_mul.sv]
`default_nettype none
// Shift-add multiplier, one multiplier bit per cycle.
module yeah_cwc_mul (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire [yeah_cwc_pkg::MUL_A_W-1:0]  i_a,
    input  wire [yeah_cwc_pkg::MUL_B_W-1:0]  i_b,
    output logic [yeah_cwc_pkg::PROD_W-1:0]  o_prod,
    output logic                             o_done
);
    localparam int unsigned PW = yeah_cwc_pkg::PROD_W;
    localparam int unsigned BW = yeah_cwc_pkg::MUL_B_W;
    localparam int unsigned CW = yeah_cwc_pkg::MUL_CNT_W;

    logic [PW-1:0] r_a;
    logic [BW-1:0] r_b;
    logic [PW-1:0] r_acc;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(BW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= PW'(i_a);
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[PW-2:0], 1'b0};
            r_b <= {1'b0, r_b[BW-1:1]};
        end
    end

    assign o_prod = r_acc;
    assign o_done = r_done;
endmodule
`default_nettype wire

[rtl/yeah_congestion_window_control_top.sv]
`default_nettype none
// YeAH congestion window decision block. One event is taken at a time.
// An RTT sample, a state change, and an ACK step that does not close a
// round evaluated with more than two samples go from the decode state
// to the result register. A loss runs a 56-step division of the flight
// size by the segment size, then a 24-step multiply. An ACK step that
// closes an evaluated round runs two 56-step divisions and a 24-step
// multiply, plus a further 56-step division and 24-step multiply when
// decongestion applies. All of these share the single serial divider and
// the single serial multiplier. The result register lets the next event
// enter while a result waits for transfer.
module yeah_congestion_window_control_top (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire [2:0]    i_cfg_idx,
    input  wire [15:0]   i_cfg_data,
    yeah_cwc_in_if.sink  i_req,
    yeah_cwc_out_if.source o_rsp
);
    localparam int unsigned WW = yeah_cwc_pkg::WORD_W;
    localparam int unsigned RW = yeah_cwc_pkg::RTT_W;
    localparam int unsigned PW = yeah_cwc_pkg::PROD_W;
    localparam int unsigned DW = yeah_cwc_pkg::DIVIDEND_W;
    localparam int unsigned VW = yeah_cwc_pkg::DIVISOR_W;
    localparam int unsigned AW = yeah_cwc_pkg::MUL_A_W;
    localparam int unsigned BW = yeah_cwc_pkg::MUL_B_W;
    localparam int unsigned NW = yeah_cwc_pkg::CNT_W;
    localparam int unsigned FW = yeah_cwc_pkg::FAST_W;

    // configuration
    logic [15:0] r_backlog_limit;
    logic [7:0]  r_drain_divisor;
    logic [4:0]  r_loss_shift;
    logic [4:0]  r_decongest_shift;
    logic [7:0]  r_delay_ratio;
    logic [15:0] r_compete_rounds;
    logic [15:0] r_fast_reset_rounds;
    logic [15:0] r_segment_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_backlog_limit     <= 16'd80;
            r_drain_divisor     <= 8'd1;
            r_loss_shift        <= 5'd3;
            r_decongest_shift   <= 5'd1;
            r_delay_ratio       <= 8'd8;
            r_compete_rounds    <= 16'd16;
            r_fast_reset_rounds <= 16'd50;
            r_segment_bytes     <= 16'd536;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                yeah_cwc_pkg::CFG_BACKLOG_LIMIT:   r_backlog_limit     <= i_cfg_data;
                yeah_cwc_pkg::CFG_DRAIN_DIVISOR:   r_drain_divisor     <= i_cfg_data[7:0];
                yeah_cwc_pkg::CFG_LOSS_SHIFT:      r_loss_shift        <= i_cfg_data[4:0];
                yeah_cwc_pkg::CFG_DECONGEST_SHIFT: r_decongest_shift   <= i_cfg_data[4:0];
                yeah_cwc_pkg::CFG_DELAY_RATIO:     r_delay_ratio       <= i_cfg_data[7:0];
                yeah_cwc_pkg::CFG_COMPETE_ROUNDS:  r_compete_rounds    <= i_cfg_data;
                yeah_cwc_pkg::CFG_FAST_RESET:      r_fast_reset_rounds <= i_cfg_data;
                yeah_cwc_pkg::CFG_SEGMENT_BYTES:   r_segment_bytes     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // latched event
    yeah_cwc_pkg::t_cmd r_cmd;
    logic [RW-1:0] r_rtt;
    logic [WW-1:0] r_cwnd, r_ssth, r_acked, r_nxt, r_flight;
    logic          r_open;

    // connection state
    logic [RW-1:0] r_base, n_base, r_rmin, n_rmin;
    logic [NW-1:0] r_cnt, n_cnt;
    logic          r_active, n_active;
    logic [WW-1:0] r_rend, n_rend, r_lastq, n_lastq, r_slow, n_slow, r_reno, n_reno;
    logic [FW-1:0] r_fast, n_fast;

    // work registers
    logic [WW-1:0] r_segq, n_segq, r_queue, n_queue;
    logic          r_slow_flag, n_slow_flag;

    // pending result
    logic [1:0]    r_res_growth, n_res_growth;
    logic          r_res_done, n_res_done, r_res_chg, n_res_chg;
    logic [WW-1:0] r_res_cwnd, n_res_cwnd, r_res_ssth, n_res_ssth;

    // output register
    logic          r_o_valid;
    logic [1:0]    r_o_growth;
    logic          r_o_done, r_o_chg;
    logic [WW-1:0] r_o_cwnd, r_o_ssth, r_o_queue;
    logic          out_load;

    yeah_cwc_pkg::t_state r_state, n_state;

    logic          div_start, div_done, mul_start, mul_done;
    logic [DW-1:0] div_dividend, div_quot;
    logic [VW-1:0] div_divisor;
    logic [AW-1:0] mul_a;
    logic [BW-1:0] mul_b;
    logic [PW-1:0] mul_prod;

    yeah_cwc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quot     (div_quot),
        .o_done     (div_done)
    );

    yeah_cwc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_prod  (mul_prod),
        .o_done  (mul_done)
    );

    logic          accept;
    logic [15:0]   seg;
    logic [7:0]    drain;
    logic [RW-1:0] qdelay;
    logic [WW-1:0] quot32;

    assign accept   = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == yeah_cwc_pkg::S_IDLE);
    assign seg      = (r_segment_bytes == '0) ? 16'd1 : r_segment_bytes;
    assign drain    = (r_drain_divisor == '0) ? 8'd1 : r_drain_divisor;
    assign qdelay   = (r_rmin > r_base) ? r_rmin - r_base : '0;
    assign quot32   = div_quot[WW-1:0];

    always_comb begin
        logic [WW-1:0] half, cut, diff, newseg, renov;
        logic [RW+7:0] dprod;
        logic [FW-1:0] fastv;
        logic          over;

        n_state      = r_state;
        n_base       = r_base;
        n_rmin       = r_rmin;
        n_cnt        = r_cnt;
        n_active     = r_active;
        n_rend       = r_rend;
        n_lastq      = r_lastq;
        n_slow       = r_slow;
        n_reno       = r_reno;
        n_fast       = r_fast;
        n_segq       = r_segq;
        n_queue      = r_queue;
        n_slow_flag  = r_slow_flag;
        n_res_growth = r_res_growth;
        n_res_done   = r_res_done;
        n_res_chg    = r_res_chg;
        n_res_cwnd   = r_res_cwnd;
        n_res_ssth   = r_res_ssth;
        div_start    = 1'b0;
        div_dividend = DW'(r_cwnd);
        div_divisor  = VW'(seg);
        mul_start    = 1'b0;
        mul_a        = quot32;
        mul_b        = BW'(seg);
        out_load     = 1'b0;
        half         = '0;
        cut          = '0;
        diff         = '0;
        newseg       = '0;
        renov        = '0;
        dprod        = '0;
        fastv        = '0;
        over         = 1'b0;

        case (r_state)
            yeah_cwc_pkg::S_IDLE: begin
                if (accept) begin
                    n_res_growth = yeah_cwc_pkg::GROWTH_SLOW_START;
                    n_res_done   = 1'b0;
                    n_res_chg    = 1'b0;
                    n_res_cwnd   = '0;
                    n_res_ssth   = '0;
                    n_state      = yeah_cwc_pkg::S_DECODE;
                end
            end
            yeah_cwc_pkg::S_DECODE: begin
                n_state = yeah_cwc_pkg::S_DONE;
                case (r_cmd)
                    yeah_cwc_pkg::CMD_RTT: begin
                        if (r_rtt != '0) begin
                            if (r_rtt < r_rmin) n_rmin = r_rtt;
                            if (r_rtt < r_base) n_base = r_rtt;
                            if (r_cnt != '1) n_cnt = r_cnt + NW'(1);
                        end
                    end
                    yeah_cwc_pkg::CMD_ACK: begin
                        if (r_cwnd < r_ssth) begin
                            n_res_growth = yeah_cwc_pkg::GROWTH_SLOW_START;
                        end else if (r_slow == '0) begin
                            n_res_growth = yeah_cwc_pkg::GROWTH_SCALABLE;
                        end else begin
                            n_res_growth = yeah_cwc_pkg::GROWTH_RENO;
                        end
                        diff = r_acked - r_rend;
                        if (!diff[WW-1]) begin
                            n_res_done = 1'b1;
                            if (r_cnt > yeah_cwc_pkg::MIN_SAMPLES) begin
                                div_start = 1'b1;
                                n_state = yeah_cwc_pkg::S_DIV_SEG;
                            end else begin
                                n_rend = r_nxt;
                                n_cnt  = '0;
                                n_rmin = '1;
                            end
                        end
                    end
                    yeah_cwc_pkg::CMD_STATE: begin
                        n_active = r_open;
                        if (r_open) begin
                            n_rend = r_nxt;
                            n_cnt  = '0;
                            n_rmin = '1;
                        end
                    end
                    default: begin
                        div_dividend = DW'(r_flight);
                        div_start    = 1'b1;
                        n_state = yeah_cwc_pkg::S_DIV_SEG;
                    end
                endcase
            end
            yeah_cwc_pkg::S_DIV_SEG: begin
                if (div_done) begin
                    if (r_cmd == yeah_cwc_pkg::CMD_LOSS) begin
                        half = (quot32 >> 1) > yeah_cwc_pkg::RENO_FLOOR ?
                               (quot32 >> 1) : yeah_cwc_pkg::RENO_FLOOR;
                        if (r_slow < WW'(r_compete_rounds)) begin
                            cut = (quot32 >> r_loss_shift) > r_lastq ?
                                  (quot32 >> r_loss_shift) : r_lastq;
                            if (half < cut) cut = half;
                        end else begin
                            cut = half;
                        end
                        mul_a     = cut;
                        mul_start = 1'b1;
                        n_state = yeah_cwc_pkg::S_MUL_LOSS;
                    end else begin
                        n_segq    = quot32;
                        mul_b     = qdelay;
                        mul_start = 1'b1;
                        n_state = yeah_cwc_pkg::S_MUL_Q;
                    end
                end
            end
            yeah_cwc_pkg::S_MUL_Q: begin
                if (mul_done) begin
                    div_dividend = mul_prod;
                    div_divisor  = r_rmin;
                    div_start    = 1'b1;
                    n_state = yeah_cwc_pkg::S_DIV_Q;
                end
            end
            yeah_cwc_pkg::S_DIV_Q: begin
                if (div_done) begin
                    n_queue = quot32;
                    over  = quot32 > WW'(r_backlog_limit);
                    dprod = qdelay * r_delay_ratio;
                    n_slow_flag = over || (dprod > (RW+8)'(r_base));
                    if (over && r_segq > r_reno) begin
                        div_dividend = DW'(quot32);
                        div_divisor  = VW'(drain);
                        div_start    = 1'b1;
                        n_state = yeah_cwc_pkg::S_DIV_CUT;
                    end else begin
                        n_state = yeah_cwc_pkg::S_ROUND;
                    end
                end
            end
            yeah_cwc_pkg::S_DIV_CUT: begin
                if (div_done) begin
                    cut = (r_segq >> r_decongest_shift);
                    if (quot32 < cut) cut = quot32;
                    diff   = r_segq - cut;
                    newseg = (diff > r_reno) ? diff : r_reno;
                    n_segq = newseg;
                    mul_a  = newseg;
                    mul_start = 1'b1;
                    n_state = yeah_cwc_pkg::S_MUL_W;
                end
            end
            yeah_cwc_pkg::S_MUL_W: begin
                if (mul_done) begin
                    n_res_chg  = 1'b1;
                    n_res_cwnd = (mul_prod[PW-1:WW] != '0) ? '1 : mul_prod[WW-1:0];
                    n_res_ssth = n_res_cwnd;
                    n_state = yeah_cwc_pkg::S_ROUND;
                end
            end
            yeah_cwc_pkg::S_ROUND: begin
                if (r_slow_flag) begin
                    if (r_reno <= yeah_cwc_pkg::RENO_FLOOR) begin
                        renov  = r_segq >> 1;
                        n_reno = (renov > yeah_cwc_pkg::RENO_FLOOR) ?
                                 renov : yeah_cwc_pkg::RENO_FLOOR;
                    end else if (r_reno != '1) begin
                        n_reno = r_reno + WW'(1);
                    end
                    if (r_slow != '1) n_slow = r_slow + WW'(1);
                end else begin
                    fastv = (r_fast != '1) ? r_fast + FW'(1) : r_fast;
                    if (fastv > FW'(r_fast_reset_rounds)) begin
                        n_reno = yeah_cwc_pkg::RENO_FLOOR;
                        n_fast = '0;
                    end else begin
                        n_fast = fastv;
                    end
                    n_slow = '0;
                end
                n_lastq = r_queue;
                n_rend  = r_nxt;
                n_cnt   = '0;
                n_rmin  = '1;
                n_state = yeah_cwc_pkg::S_DONE;
            end
            yeah_cwc_pkg::S_MUL_LOSS: begin
                if (mul_done) begin
                    n_res_ssth = (mul_prod >= PW'(r_flight)) ? '0 :
                                 r_flight - mul_prod[WW-1:0];
                    n_fast = '0;
                    renov  = r_reno >> 1;
                    n_reno = (renov > yeah_cwc_pkg::RENO_FLOOR) ?
                             renov : yeah_cwc_pkg::RENO_FLOOR;
                    n_state = yeah_cwc_pkg::S_DONE;
                end
            end
            yeah_cwc_pkg::S_DONE: begin
                if (!r_o_valid || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = yeah_cwc_pkg::S_IDLE;
                end
            end
            default: n_state = yeah_cwc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= yeah_cwc_pkg::S_IDLE;
            r_base   <= '1;
            r_rmin   <= '1;
            r_cnt    <= '0;
            r_active <= 1'b1;
            r_rend   <= '0;
            r_lastq  <= '0;
            r_slow   <= '0;
            r_reno   <= yeah_cwc_pkg::RENO_FLOOR;
            r_fast   <= '0;
        end else begin
            r_state  <= n_state;
            r_base   <= n_base;
            r_rmin   <= n_rmin;
            r_cnt    <= n_cnt;
            r_active <= n_active;
            r_rend   <= n_rend;
            r_lastq  <= n_lastq;
            r_slow   <= n_slow;
            r_reno   <= n_reno;
            r_fast   <= n_fast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= yeah_cwc_pkg::t_cmd'(i_req.cmd);
            r_rtt    <= i_req.rtt_us;
            r_cwnd   <= i_req.cwnd_bytes;
            r_ssth   <= i_req.ssthresh_bytes;
            r_acked  <= i_req.acked_seq;
            r_nxt    <= i_req.next_seq;
            r_flight <= i_req.in_flight_bytes;
            r_open   <= i_req.state_open;
        end
        r_segq       <= n_segq;
        r_queue      <= n_queue;
        r_slow_flag  <= n_slow_flag;
        r_res_growth <= n_res_growth;
        r_res_done   <= n_res_done;
        r_res_chg    <= n_res_chg;
        r_res_cwnd   <= n_res_cwnd;
        r_res_ssth   <= n_res_ssth;
    end

    // result register: hold until transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_growth <= r_res_growth;
            r_o_done   <= r_res_done;
            r_o_chg    <= r_res_chg;
            r_o_cwnd   <= r_res_cwnd;
            r_o_ssth   <= r_res_ssth;
            r_o_queue  <= r_lastq;
        end
    end

    assign o_rsp.valid          = r_o_valid;
    assign o_rsp.growth_mode    = r_o_growth;
    assign o_rsp.round_done     = r_o_done;
    assign o_rsp.window_changed = r_o_chg;
    assign o_rsp.cwnd_out       = r_o_cwnd;
    assign o_rsp.ssthresh_out   = r_o_ssth;
    assign o_rsp.queue_estimate = r_o_queue;

`ifndef NO_ASSERTIONS
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(div_done && mul_done))
        else $error("divider and multiplier finished together");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_req.ready)
        else $error("event taken while another is in progress");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_o_valid || o_rsp.ready))
        else $error("result register overwritten before transfer");
`endif
endmodule
`default_nettype wire

[sim/yeah_cwc_checker.sv]
module yeah_cwc_checker (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire [2:0]    i_cfg_idx,
    input  wire [15:0]   i_cfg_data,
    yeah_cwc_in_if       req,
    yeah_cwc_out_if      rsp,
    output int unsigned  o_fail_cnt,
    output int unsigned  o_pending
);

    typedef struct {
        yeah_cwc_pkg::t_growth growth;
        logic        round_done;
        logic        changed;
        logic [31:0] cwnd;
        logic [31:0] ssth;
        logic [31:0] queue;
    } t_decision;

    t_decision decision_q[$];

    // configuration copy
    logic [15:0] backlog_limit;
    logic [7:0]  drain_div;
    logic [4:0]  loss_shift;
    logic [4:0]  decongest_shift;
    logic [7:0]  delay_ratio;
    logic [15:0] compete_rounds;
    logic [15:0] fast_reset_rounds;
    logic [15:0] seg_bytes;

    // connection state copy
    logic [23:0] base_rtt;
    logic [23:0] round_min;
    logic [15:0] samples;
    logic        active;
    logic [31:0] round_end;
    logic [31:0] last_queue;
    logic [31:0] slow_rounds;
    logic [31:0] reno_est;
    logic [16:0] fast_rounds;

    function automatic logic [31:0] seg_size();
        return (seg_bytes == 0) ? 32'd1 : {16'd0, seg_bytes};
    endfunction

    task automatic start_round(input logic [31:0] seq);
        round_end = seq;
        samples   = '0;
        round_min = '1;
    endtask

    task automatic close_round(input logic [31:0] cwnd, inout t_decision d);
        logic [31:0] seg;
        logic [31:0] seg_cwnd;
        logic [31:0] qdelay;
        logic [31:0] queue;
        logic [31:0] div;
        logic [31:0] cut;
        logic [63:0] w;
        logic        over;
        logic        delayed;
        seg      = seg_size();
        seg_cwnd = cwnd / seg;
        qdelay   = (round_min > base_rtt) ? 32'(round_min - base_rtt) : 32'd0;
        queue    = 32'((64'(seg_cwnd) * 64'(qdelay)) / 64'(round_min));
        over     = queue > {16'd0, backlog_limit};
        delayed  = 64'(qdelay) * 64'(delay_ratio) > 64'(base_rtt);
        if (over || delayed) begin
            if (over && seg_cwnd > reno_est) begin
                div = (drain_div == 0) ? 32'd1 : {24'd0, drain_div};
                cut = queue / div;
                if ((seg_cwnd >> decongest_shift) < cut)
                    cut = seg_cwnd >> decongest_shift;
                seg_cwnd = seg_cwnd - cut;
                if (seg_cwnd < reno_est)
                    seg_cwnd = reno_est;
                w = 64'(seg_cwnd) * 64'(seg);
                if (w > 64'hFFFF_FFFF)
                    w = 64'hFFFF_FFFF;
                d.changed = 1'b1;
                d.cwnd    = w[31:0];
                d.ssth    = w[31:0];
            end
            if (reno_est <= yeah_cwc_pkg::RENO_FLOOR)
                reno_est = ((seg_cwnd >> 1) > yeah_cwc_pkg::RENO_FLOOR) ?
                           (seg_cwnd >> 1) : yeah_cwc_pkg::RENO_FLOOR;
            else if (reno_est != '1)
                reno_est++;
            if (slow_rounds != '1)
                slow_rounds++;
        end else begin
            if (fast_rounds != '1)
                fast_rounds++;
            if (32'(fast_rounds) > 32'(fast_reset_rounds)) begin
                reno_est    = yeah_cwc_pkg::RENO_FLOOR;
                fast_rounds = '0;
            end
            slow_rounds = '0;
        end
        last_queue = queue;
    endtask

    task automatic predict_event();
        t_decision   d;
        logic [31:0] seg;
        logic [31:0] seg_flight;
        logic [31:0] half;
        logic [31:0] cut;
        logic [63:0] cut_bytes;
        d = '{yeah_cwc_pkg::GROWTH_SLOW_START, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0};
        case (yeah_cwc_pkg::t_cmd'(req.cmd))
            yeah_cwc_pkg::CMD_RTT: begin
                if (req.rtt_us != 0) begin
                    if (req.rtt_us < round_min) round_min = req.rtt_us;
                    if (req.rtt_us < base_rtt)  base_rtt  = req.rtt_us;
                    if (samples != '1) samples++;
                end
            end
            yeah_cwc_pkg::CMD_ACK: begin
                if (req.cwnd_bytes < req.ssthresh_bytes)
                    d.growth = yeah_cwc_pkg::GROWTH_SLOW_START;
                else if (slow_rounds == 0)
                    d.growth = yeah_cwc_pkg::GROWTH_SCALABLE;
                else
                    d.growth = yeah_cwc_pkg::GROWTH_RENO;
                // round closes when acked is at or past round end, serial order
                if (!(32'(req.acked_seq - round_end) >> 31)) begin
                    d.round_done = 1'b1;
                    if (samples > yeah_cwc_pkg::MIN_SAMPLES)
                        close_round(req.cwnd_bytes, d);
                    start_round(req.next_seq);
                end
            end
            yeah_cwc_pkg::CMD_STATE: begin
                if (req.state_open) begin
                    active = 1'b1;
                    start_round(req.next_seq);
                end else begin
                    active = 1'b0;
                end
            end
            default: begin
                seg        = seg_size();
                seg_flight = req.in_flight_bytes / seg;
                half       = ((seg_flight >> 1) > yeah_cwc_pkg::RENO_FLOOR) ?
                             (seg_flight >> 1) : yeah_cwc_pkg::RENO_FLOOR;
                if (slow_rounds < 32'(compete_rounds)) begin
                    cut = seg_flight >> loss_shift;
                    if (last_queue > cut) cut = last_queue;
                    if (half < cut)       cut = half;
                end else begin
                    cut = half;
                end
                fast_rounds = '0;
                reno_est    = ((reno_est >> 1) > yeah_cwc_pkg::RENO_FLOOR) ?
                              (reno_est >> 1) : yeah_cwc_pkg::RENO_FLOOR;
                cut_bytes   = 64'(cut) * 64'(seg);
                d.ssth      = (cut_bytes >= 64'(req.in_flight_bytes)) ? 32'd0 :
                              32'(64'(req.in_flight_bytes) - cut_bytes);
            end
        endcase
        d.queue = last_queue;
        decision_q.push_back(d);
    endtask

    task automatic compare_result();
        t_decision d;
        if (decision_q.size() == 0) begin
            o_fail_cnt++;
            if (o_fail_cnt <= 10)
                $display("%0t: result with nothing pending", $realtime);
            return;
        end
        d = decision_q.pop_front();
        if (rsp.growth_mode !== d.growth || rsp.round_done !== d.round_done ||
            rsp.window_changed !== d.changed || rsp.cwnd_out !== d.cwnd ||
            rsp.ssthresh_out !== d.ssth || rsp.queue_estimate !== d.queue) begin
            o_fail_cnt++;
            if (o_fail_cnt <= 10)
                $display("%0t: mismatch exp g=%0d r=%0b c=%0b cw=%h ss=%h q=%h",
                         $realtime, d.growth, d.round_done, d.changed, d.cwnd,
                         d.ssth, d.queue,
                         " got g=%0d r=%0b c=%0b cw=%h ss=%h q=%h", rsp.growth_mode,
                         rsp.round_done, rsp.window_changed, rsp.cwnd_out,
                         rsp.ssthresh_out, rsp.queue_estimate);
        end
    endtask

    initial o_fail_cnt = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            backlog_limit     = 16'd80;
            drain_div         = 8'd1;
            loss_shift        = 5'd3;
            decongest_shift   = 5'd1;
            delay_ratio       = 8'd8;
            compete_rounds    = 16'd16;
            fast_reset_rounds = 16'd50;
            seg_bytes         = 16'd536;
            base_rtt          = '1;
            round_min         = '1;
            samples           = '0;
            active            = 1'b1;
            round_end         = '0;
            last_queue        = '0;
            slow_rounds       = '0;
            reno_est          = yeah_cwc_pkg::RENO_FLOOR;
            fast_rounds       = '0;
            decision_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    yeah_cwc_pkg::CFG_BACKLOG_LIMIT:   backlog_limit     = i_cfg_data;
                    yeah_cwc_pkg::CFG_DRAIN_DIVISOR:   drain_div         = i_cfg_data[7:0];
                    yeah_cwc_pkg::CFG_LOSS_SHIFT:      loss_shift        = i_cfg_data[4:0];
                    yeah_cwc_pkg::CFG_DECONGEST_SHIFT: decongest_shift   = i_cfg_data[4:0];
                    yeah_cwc_pkg::CFG_DELAY_RATIO:     delay_ratio       = i_cfg_data[7:0];
                    yeah_cwc_pkg::CFG_COMPETE_ROUNDS:  compete_rounds    = i_cfg_data;
                    yeah_cwc_pkg::CFG_FAST_RESET:      fast_reset_rounds = i_cfg_data;
                    default:                           seg_bytes         = i_cfg_data;
                endcase
            end
            if (rsp.valid && rsp.ready)
                compare_result();
            if (req.valid && req.ready)
                predict_event();
        end
        o_pending = decision_q.size();
    end

endmodule

[sim/yeah_congestion_window_control_top_test.sv]
module yeah_congestion_window_control_top_test;

    localparam int unsigned IDLE_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    int unsigned fail_cnt;
    int unsigned pending;
    int unsigned result_cnt;
    int unsigned idle_cycles;
    bit          held_off;

    // sequence tracking so most acks close a round
    logic [31:0] seq_next;
    logic [23:0] rtt_floor;

    yeah_cwc_in_if  req_if ();
    yeah_cwc_out_if rsp_if ();

    yeah_congestion_window_control_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if.sink),
        .o_rsp      (rsp_if.source)
    );

    yeah_cwc_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .req        (req_if),
        .rsp        (rsp_if),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rsp_if.valid && rsp_if.ready)
            result_cnt <= result_cnt + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[yeah_congestion_window_control_top] ERROR");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    // receiver: bursts and gaps, plus one long hold-off
    initial begin
        int unsigned n;
        rsp_if.ready = 1'b0;
        held_off     = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!held_off && result_cnt > 300) begin
                held_off = 1'b1;
                rsp_if.ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
            end
            n = $urandom_range(1, 30);
            rsp_if.ready <= 1'b1;
            repeat (n) @(posedge i_clk);
            n = pick_gap();
            if (n > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    task automatic send(input yeah_cwc_pkg::t_cmd c, input logic [23:0] rtt,
                        input logic [31:0] cwnd,
                        input logic [31:0] ssth, input logic [31:0] acked,
                        input logic [31:0] nxt, input logic [31:0] flight,
                        input logic open);
        int unsigned gap;
        req_if.valid           <= 1'b1;
        req_if.cmd             <= c;
        req_if.rtt_us          <= rtt;
        req_if.cwnd_bytes      <= cwnd;
        req_if.ssthresh_bytes  <= ssth;
        req_if.acked_seq       <= acked;
        req_if.next_seq        <= nxt;
        req_if.in_flight_bytes <= flight;
        req_if.state_open      <= open;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // no result is pending here, and the block is idle again
        repeat (300) @(posedge i_clk);
    endtask

    task automatic random_event();
        int unsigned r;
        logic [31:0] cwnd;
        logic [31:0] acked;
        logic [31:0] nxt;
        logic [23:0] rtt;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0)
            cwnd = $urandom;
        else
            cwnd = $urandom_range(1, 4000) * $urandom_range(1, 2000);
        if (r < 45) begin
            if ($urandom_range(0, 19) == 0)
                rtt = ($urandom_range(0, 1) != 0) ? 24'd0 : 24'($urandom);
            else
                rtt = rtt_floor + 24'($urandom_range(0, rtt_floor));
            send(yeah_cwc_pkg::CMD_RTT, rtt, $urandom, $urandom, $urandom, $urandom,
                 $urandom, 1'($urandom));
        end else if (r < 82) begin
            if ($urandom_range(0, 9) == 0) begin
                acked = $urandom;
            end else begin
                acked = seq_next + $urandom_range(0, 3000);
                if ($urandom_range(0, 4) == 0) acked = seq_next - $urandom_range(1, 3000);
            end
            nxt      = acked + $urandom_range(1, 200000);
            seq_next = nxt;
            send(yeah_cwc_pkg::CMD_ACK, 24'($urandom), cwnd,
                 ($urandom_range(0, 1) != 0) ? cwnd + 32'($urandom_range(0, 9)) - 5 : $urandom,
                 acked, nxt, $urandom, 1'($urandom));
        end else if (r < 88) begin
            nxt = $urandom;
            if (req_if.state_open) seq_next = nxt;
            send(yeah_cwc_pkg::CMD_STATE, 24'($urandom), $urandom, $urandom, $urandom, nxt,
                 $urandom, 1'($urandom_range(0, 3) != 0));
            seq_next = nxt;
        end else begin
            send(yeah_cwc_pkg::CMD_LOSS, 24'($urandom), $urandom, $urandom, $urandom,
                 $urandom, ($urandom_range(0, 2) == 0) ? $urandom : cwnd, 1'($urandom));
        end
    endtask

    task automatic random_phase(input int unsigned n_items);
        rtt_floor = 24'($urandom_range(100, 60000));
        repeat (n_items) random_event();
        drain();
    endtask

    initial begin
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_idx              = yeah_cwc_pkg::CFG_BACKLOG_LIMIT;
        i_cfg_data             = '0;
        req_if.valid           = 1'b0;
        req_if.cmd             = yeah_cwc_pkg::CMD_RTT;
        req_if.rtt_us          = '0;
        req_if.cwnd_bytes      = '0;
        req_if.ssthresh_bytes  = '0;
        req_if.acked_seq       = '0;
        req_if.next_seq        = '0;
        req_if.in_flight_bytes = '0;
        req_if.state_open      = 1'b0;
        idle_cycles            = 0;
        result_cnt             = 0;
        seq_next               = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every event kind, rollover and zero cases
        send(yeah_cwc_pkg::CMD_LOSS, 24'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        send(yeah_cwc_pkg::CMD_RTT, 24'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        send(yeah_cwc_pkg::CMD_RTT, 24'hFFFFFF, '1, '1, '1, '1, '1, 1'b1);
        send(yeah_cwc_pkg::CMD_RTT, 24'd1000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        send(yeah_cwc_pkg::CMD_RTT, 24'd3000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        send(yeah_cwc_pkg::CMD_ACK, 24'd0, 32'd1000, 32'd2000, 32'd0, 32'd50000, 32'd0,
             1'b0);
        send(yeah_cwc_pkg::CMD_RTT, 24'd1000, '1, '1, '1, '1, '1, 1'b1);
        send(yeah_cwc_pkg::CMD_RTT, 24'd1100, '1, '1, '1, '1, '1, 1'b1);
        send(yeah_cwc_pkg::CMD_RTT, 24'd1200, '1, '1, '1, '1, '1, 1'b1);
        send(yeah_cwc_pkg::CMD_ACK, 24'hFFFFFF, '1, 32'd0, 32'd50000, 32'd90000, '1, 1'b1);
        send(yeah_cwc_pkg::CMD_RTT, 24'd5000, '1, '1, '1, '1, '1, 1'b1);
        send(yeah_cwc_pkg::CMD_RTT, 24'd6000, '1, '1, '1, '1, '1, 1'b1);
        send(yeah_cwc_pkg::CMD_RTT, 24'd7000, '1, '1, '1, '1, '1, 1'b1);
        send(yeah_cwc_pkg::CMD_ACK, 24'd0, 32'd5360000, 32'd5360000, 32'd89999, 32'd100,
             32'd0, 1'b0);
        send(yeah_cwc_pkg::CMD_ACK, 24'd0, 32'd5360000, 32'd5360000, 32'h8000_0063,
             32'd100, 32'd0, 1'b0);
        send(yeah_cwc_pkg::CMD_ACK, 24'd0, 32'd5360000, 32'd5360000, 32'h8000_0064,
             32'd100, 32'd0, 1'b0);
        send(yeah_cwc_pkg::CMD_STATE, 24'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        send(yeah_cwc_pkg::CMD_STATE, '1, '1, '1, '1, 32'd7, '1, 1'b1);
        send(yeah_cwc_pkg::CMD_LOSS, 24'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF,
             1'b0);
        send(yeah_cwc_pkg::CMD_LOSS, 24'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1072, 1'b0);
        seq_next = 32'd7;
        drain();

        random_phase(300);

        // low extremes, zero divisors treated as one
        cfg_write(yeah_cwc_pkg::CFG_BACKLOG_LIMIT, 16'd0);
        cfg_write(yeah_cwc_pkg::CFG_DRAIN_DIVISOR, 16'd0);
        cfg_write(yeah_cwc_pkg::CFG_LOSS_SHIFT, 16'd0);
        cfg_write(yeah_cwc_pkg::CFG_DECONGEST_SHIFT, 16'd0);
        cfg_write(yeah_cwc_pkg::CFG_DELAY_RATIO, 16'd1);
        cfg_write(yeah_cwc_pkg::CFG_COMPETE_ROUNDS, 16'd0);
        cfg_write(yeah_cwc_pkg::CFG_FAST_RESET, 16'd0);
        cfg_write(yeah_cwc_pkg::CFG_SEGMENT_BYTES, 16'd0);
        random_phase(230);

        // high extremes
        cfg_write(yeah_cwc_pkg::CFG_BACKLOG_LIMIT, 16'hFFFF);
        cfg_write(yeah_cwc_pkg::CFG_DRAIN_DIVISOR, 16'd255);
        cfg_write(yeah_cwc_pkg::CFG_LOSS_SHIFT, 16'd31);
        cfg_write(yeah_cwc_pkg::CFG_DECONGEST_SHIFT, 16'd31);
        cfg_write(yeah_cwc_pkg::CFG_DELAY_RATIO, 16'd255);
        cfg_write(yeah_cwc_pkg::CFG_COMPETE_ROUNDS, 16'hFFFF);
        cfg_write(yeah_cwc_pkg::CFG_FAST_RESET, 16'hFFFF);
        cfg_write(yeah_cwc_pkg::CFG_SEGMENT_BYTES, 16'hFFFF);
        random_phase(230);

        repeat (2) begin
            cfg_write(yeah_cwc_pkg::CFG_BACKLOG_LIMIT, 16'($urandom_range(0, 300)));
            cfg_write(yeah_cwc_pkg::CFG_DRAIN_DIVISOR, 16'($urandom_range(1, 8)));
            cfg_write(yeah_cwc_pkg::CFG_LOSS_SHIFT, 16'($urandom_range(0, 5)));
            cfg_write(yeah_cwc_pkg::CFG_DECONGEST_SHIFT, 16'($urandom_range(0, 4)));
            cfg_write(yeah_cwc_pkg::CFG_DELAY_RATIO, 16'($urandom_range(1, 40)));
            cfg_write(yeah_cwc_pkg::CFG_COMPETE_ROUNDS, 16'($urandom_range(0, 6)));
            cfg_write(yeah_cwc_pkg::CFG_FAST_RESET, 16'($urandom_range(0, 8)));
            cfg_write(yeah_cwc_pkg::CFG_SEGMENT_BYTES, 16'($urandom_range(1, 1500)));
            random_phase(235);
        end

        if (fail_cnt == 0 && pending == 0)
            $display("[yeah_congestion_window_control_top] OK");
        else
            $display("[yeah_congestion_window_control_top] ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/yeah_cwc_pkg.sv
rtl/yeah_cwc_in_if.sv
rtl/yeah_cwc_out_if.sv
rtl/yeah_cwc_div.sv
rtl/yeah_cwc_mul.sv
rtl/yeah_congestion_window_control_top.sv
sim/yeah_cwc_checker.sv
sim/yeah_congestion_window_control_top_test.sv
